// ----- hdl/gle_pkg.sv -----
// Shared types and constants for the glyph layout engine.
`default_nettype none

package gle_pkg;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_CHAR  = 2'd2,
      OP_END   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_ORIGIN_X      = 3'd0,
      REG_ORIGIN_Y      = 3'd1,
      REG_SCALE_X       = 3'd2,
      REG_SCALE_Y       = 3'd3,
      REG_SPACE_ADVANCE = 3'd4,
      REG_LINE_HEIGHT   = 3'd5
   } reg_index_type;

   localparam logic       KIND_QUAD = 1'b0;
   localparam logic       KIND_BOX  = 1'b1;

   localparam logic [7:0] CODE_NEWLINE     = 8'd10;
   localparam logic [7:0] CODE_SPACE       = 8'd32;
   localparam logic [7:0] CODE_PRINT_FIRST = 8'd33;
   localparam logic [7:0] CODE_PRINT_LAST  = 8'd126;

   // 14.6 advances are taken as whole pixels
   localparam int         ADV_SHIFT = 6;
   localparam int         ADV_W     = 20;
   localparam int         ADV_PIX_W = ADV_W - ADV_SHIFT;

   localparam logic [15:0] SCALE_RESET = 16'd256;

   // one glyph's stored metrics and texture handle
   typedef struct packed {
      logic [15:0]      bearing_left;
      logic [15:0]      bearing_top;
      logic [15:0]      bitmap_w;
      logic [15:0]      bitmap_h;
      logic [ADV_W-1:0] advance;
      logic [63:0]      handle;
   } glyph_entry_type;

   // decoded item held between the input register and the result stage
   typedef struct packed {
      opcode_type op;
      logic       is_space;
      logic       is_newline;
      logic       is_glyph;
   } item_type;

   function automatic logic signed [31:0] sat_s32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
         r = v[31:0];
      end else if (v[33]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   function automatic logic [31:0] sat_u32(input logic [32:0] v);
      logic [31:0] r;
      r = v[32] ? 32'hFFFF_FFFF : v[31:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/glyph_layout_engine.sv -----
// Glyph layout engine: glyph table, pen and bounding box tracking, quad output.
// An item is held in the input register, its result in the result register.
// Throughput: one item per cycle; the glyph table read at transfer and the
// single result stage set this, and ready drops only while the result register
// holds an untaken result and the input register is also full.
// Reset (synchronous): clears valids, pen and box, restores register defaults.
// The glyph table is not cleared; entries are undefined until loaded.
`default_nettype none

module glyph_layout_engine #(
   parameter int GLYPH_COUNT = 94,
   parameter int FIRST_CODE  = 33
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_char_code,
   input  wire logic signed [15:0] req_bearing_left,
   input  wire logic signed [15:0] req_bearing_top,
   input  wire logic [15:0] req_bitmap_w,
   input  wire logic [15:0] req_bitmap_h,
   input  wire logic [gle_pkg::ADV_W-1:0] req_advance_units,
   input  wire logic [63:0] req_texture_ref,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [31:0]      rsp_extent_w,
   output logic [31:0]      rsp_extent_h,
   output logic [63:0]      rsp_glyph_handle,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   import gle_pkg::*;

   localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

   // ---------------- configuration registers ----------------
   logic signed [31:0] origin_x_ff, origin_y_ff;
   logic [15:0]        scale_x_ff, scale_y_ff;
   logic [ADV_W-1:0]   space_advance_ff, line_height_ff;
   reg_index_type      csr_index;
   logic               csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         scale_x_ff       <= SCALE_RESET;
         scale_y_ff       <= SCALE_RESET;
         space_advance_ff <= '0;
         line_height_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_ORIGIN_X:      origin_x_ff      <= csr_pwdata;
            REG_ORIGIN_Y:      origin_y_ff      <= csr_pwdata;
            REG_SCALE_X:       scale_x_ff       <= csr_pwdata[15:0];
            REG_SCALE_Y:       scale_y_ff       <= csr_pwdata[15:0];
            REG_SPACE_ADVANCE: space_advance_ff <= csr_pwdata[ADV_W-1:0];
            REG_LINE_HEIGHT:   line_height_ff   <= csr_pwdata[ADV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ORIGIN_X:      csr_prdata = origin_x_ff;
         REG_ORIGIN_Y:      csr_prdata = origin_y_ff;
         REG_SCALE_X:       csr_prdata = {16'd0, scale_x_ff};
         REG_SCALE_Y:       csr_prdata = {16'd0, scale_y_ff};
         REG_SPACE_ADVANCE: csr_prdata = {{(32-ADV_W){1'b0}}, space_advance_ff};
         REG_LINE_HEIGHT:   csr_prdata = {{(32-ADV_W){1'b0}}, line_height_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------- input decode and glyph table ----------------
   logic            req_fire;
   logic [8:0]      req_diff;
   logic            req_idx_ok;
   logic [IDX_W-1:0] req_addr;
   opcode_type      req_op;
   item_type        req_item;
   glyph_entry_type req_entry;

   assign req_fire   = req_valid && req_ready;
   assign req_op     = opcode_type'(req_opcode);
   assign req_diff   = {1'b0, req_char_code} - 9'(FIRST_CODE);
   assign req_idx_ok = !req_diff[8] && (req_diff < 9'(GLYPH_COUNT));
   assign req_addr   = req_diff[IDX_W-1:0];

   always_comb begin
      req_item.op         = req_op;
      req_item.is_space   = (req_char_code == CODE_SPACE);
      req_item.is_newline = (req_char_code == CODE_NEWLINE);
      req_item.is_glyph   = req_idx_ok && (req_char_code >= CODE_PRINT_FIRST)
                            && (req_char_code <= CODE_PRINT_LAST);
      req_entry.bearing_left = req_bearing_left;
      req_entry.bearing_top  = req_bearing_top;
      req_entry.bitmap_w     = req_bitmap_w;
      req_entry.bitmap_h     = req_bitmap_h;
      req_entry.advance      = req_advance_units;
      req_entry.handle       = req_texture_ref;
   end

   glyph_entry_type tbl_mem [GLYPH_COUNT];
   glyph_entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (req_fire && req_op == OP_LOAD && req_idx_ok) begin
         tbl_mem[req_addr] <= req_entry;
      end
   end

   // read alongside the transfer so the entry lines up with the input register
   always_ff @(posedge clock) begin
      if (req_fire && req_op == OP_CHAR && req_item.is_glyph) begin
         rd_ff <= tbl_mem[req_addr];
      end
   end

   // ---------------- input register ----------------
   logic     s1_valid_ff, s1_valid_in;
   item_type s1_item_ff;
   logic     fire;

   assign fire        = s1_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready   = !s1_valid_ff || fire;
   assign s1_valid_in = req_fire ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_item;
      end
   end

   // ---------------- layout arithmetic ----------------
   logic signed [31:0] pen_x_ff, pen_y_ff, box_x_ff, box_y_ff;
   logic [31:0]        box_w_ff, box_h_ff;
   logic signed [31:0] pen_x_in, pen_y_in, box_x_in, box_y_in;
   logic [31:0]        box_w_in, box_h_in;

   logic [ADV_PIX_W-1:0] adv_units;
   logic [15:0]          adv_scale;
   logic [29:0]          adv_prod;
   logic signed [32:0]   bx_prod, ty_prod;
   logic [31:0]          gw, gh;
   logic signed [31:0]   gx, gy;
   logic signed [31:0]   pen_base, pen_step;
   logic [31:0]          box_base, box_inc, box_step;
   logic                 is_space, is_newline, is_glyph;

   assign is_space   = (s1_item_ff.op == OP_CHAR) && s1_item_ff.is_space;
   assign is_newline = (s1_item_ff.op == OP_CHAR) && s1_item_ff.is_newline;
   assign is_glyph   = (s1_item_ff.op == OP_CHAR) && s1_item_ff.is_glyph;

   always_comb begin
      if (is_space) begin
         adv_units = space_advance_ff[ADV_W-1:ADV_SHIFT];
      end else if (is_newline) begin
         adv_units = line_height_ff[ADV_W-1:ADV_SHIFT];
      end else begin
         adv_units = rd_ff.advance[ADV_W-1:ADV_SHIFT];
      end
   end

   assign adv_scale = is_newline ? scale_y_ff : scale_x_ff;
   assign adv_prod  = 30'(adv_units) * 30'(adv_scale);

   assign bx_prod = $signed(rd_ff.bearing_left) * $signed({1'b0, scale_x_ff});
   assign ty_prod = $signed(rd_ff.bearing_top) * $signed({1'b0, scale_y_ff});
   assign gw      = 32'(rd_ff.bitmap_w) * 32'(scale_x_ff);
   assign gh      = 32'(rd_ff.bitmap_h) * 32'(scale_y_ff);
   assign gx      = sat_s32(34'(pen_x_ff) + 34'(bx_prod));
   assign gy      = sat_s32(34'(pen_y_ff) - 34'(ty_prod));

   // newline moves y and grows height; space and glyphs move x and grow width
   assign pen_base = is_newline ? pen_y_ff : pen_x_ff;
   assign pen_step = sat_s32(34'(pen_base) + $signed(34'(adv_prod)));
   assign box_base = is_newline ? box_h_ff : box_w_ff;
   assign box_inc  = is_glyph ? gw : 32'(adv_prod);
   assign box_step = sat_u32(33'(box_base) + 33'(box_inc));

   always_comb begin
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      box_x_in = box_x_ff;
      box_y_in = box_y_ff;
      box_w_in = box_w_ff;
      box_h_in = box_h_ff;
      if (fire) begin
         if (s1_item_ff.op == OP_START) begin
            pen_x_in = origin_x_ff;
            pen_y_in = origin_y_ff;
            box_x_in = origin_x_ff;
            box_y_in = origin_y_ff;
            box_w_in = '0;
            box_h_in = '0;
         end else if (is_space) begin
            pen_x_in = pen_step;
            box_w_in = box_step;
         end else if (is_newline) begin
            pen_x_in = origin_x_ff;
            pen_y_in = pen_step;
            box_h_in = box_step;
         end else if (is_glyph) begin
            pen_x_in = pen_step;
            box_w_in = box_step;
            if (gy < box_y_ff) begin
               box_y_in = gy;
            end
            if (gh > box_h_ff) begin
               box_h_in = gh;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= '0;
         box_x_ff <= '0;
         box_y_ff <= '0;
         box_w_ff <= '0;
         box_h_ff <= '0;
      end else begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
         box_x_ff <= box_x_in;
         box_y_ff <= box_y_in;
         box_w_ff <= box_w_in;
         box_h_ff <= box_h_in;
      end
   end

   // ---------------- result register ----------------
   logic rsp_valid_ff, rsp_valid_in;
   logic emit_quad, emit_box;

   assign emit_quad = fire && is_glyph;
   assign emit_box  = fire && (s1_item_ff.op == OP_END);

   always_comb begin
      if (emit_quad || emit_box) begin
         rsp_valid_in = 1'b1;
      end else if (fire || rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   logic               rsp_kind_ff;
   logic signed [31:0] rsp_pos_x_ff, rsp_pos_y_ff;
   logic [31:0]        rsp_extent_w_ff, rsp_extent_h_ff;
   logic [63:0]        rsp_glyph_handle_ff;

   always_ff @(posedge clock) begin
      if (emit_quad) begin
         rsp_kind_ff         <= KIND_QUAD;
         rsp_pos_x_ff        <= gx;
         rsp_pos_y_ff        <= gy;
         rsp_extent_w_ff     <= gw;
         rsp_extent_h_ff     <= gh;
         rsp_glyph_handle_ff <= rd_ff.handle;
      end else if (emit_box) begin
         rsp_kind_ff         <= KIND_BOX;
         rsp_pos_x_ff        <= box_x_ff;
         rsp_pos_y_ff        <= box_y_ff;
         rsp_extent_w_ff     <= box_w_ff;
         rsp_extent_h_ff     <= box_h_ff;
         rsp_glyph_handle_ff <= '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_pos_x        = rsp_pos_x_ff;
   assign rsp_pos_y        = rsp_pos_y_ff;
   assign rsp_extent_w     = rsp_extent_w_ff;
   assign rsp_extent_h     = rsp_extent_h_ff;
   assign rsp_glyph_handle = rsp_glyph_handle_ff;

   // ---------------- assertions ----------------
   // a new result needs an item that was waiting in the input register
   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff))
      else $error("result appeared without a held item");

   // stall only when both registers are full and the output is blocked
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid && !rsp_ready))
      else $error("input stalled without backpressure");

   // box results carry no texture handle
   a_box_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_BOX) |-> (rsp_glyph_handle == 64'd0))
      else $error("box result with nonzero handle");

   // an untaken result holds when nothing new fires
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pos_x)))
      else $error("stalled result changed");

   // reset puts the pen and the box at zero
   a_reset_pen: assert property (@(posedge clock)
      reset |=> (pen_x_ff == 32'sd0 && pen_y_ff == 32'sd0 && box_w_ff == 32'd0))
      else $error("pen or box not cleared by reset");

endmodule

`default_nettype wire

// ----- tb/tb_glyph_layout_engine.sv -----
// Self-checking testbench for the glyph layout engine: APB setup, item stream, result checks.
module tb_glyph_layout_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import gle_pkg::*;

   localparam int GLYPHS          = 94;
   localparam int FIRST           = 33;
   localparam int BLOCKS          = 9;
   localparam int BLOCK_ITEMS     = 150;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 6;

   typedef struct packed {
      opcode_type         op;
      logic [7:0]         code;
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic [15:0]        w;
      logic [15:0]        h;
      logic [ADV_W-1:0]   adv;
      logic [63:0]        handle;
   } glyph_item_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [31:0]        w;
      logic [31:0]        h;
      logic [63:0]        handle;
   } layout_result_type;

   // tracks pen, box and glyph store; holds the quads and boxes still owed by the block
   class layout_checker;
      logic signed [31:0] origin_x, origin_y;
      logic [15:0]        scale_x, scale_y;
      logic [ADV_W-1:0]   space_units, line_units;
      logic signed [15:0] left_tab [GLYPHS];
      logic signed [15:0] top_tab [GLYPHS];
      logic [15:0]        w_tab [GLYPHS];
      logic [15:0]        h_tab [GLYPHS];
      logic [ADV_W-1:0]   adv_tab [GLYPHS];
      logic [63:0]        handle_tab [GLYPHS];
      bit                 loaded [GLYPHS];
      logic signed [31:0] pen_x, pen_y, box_x, box_y;
      logic [31:0]        box_w, box_h;
      layout_result_type  due_outputs [$];
      int                 mismatches;

      function new();
         origin_x    = 0;
         origin_y    = 0;
         scale_x     = SCALE_RESET;
         scale_y     = SCALE_RESET;
         space_units = 0;
         line_units  = 0;
         pen_x       = 0;
         pen_y       = 0;
         box_x       = 0;
         box_y       = 0;
         box_w       = 0;
         box_h       = 0;
         mismatches  = 0;
         foreach (loaded[i]) loaded[i] = 1'b0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function logic signed [31:0] clamp_s32(longint v);
         if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
         if (v < -64'sd2147483648) return 32'sh8000_0000;
         return v[31:0];
      endfunction

      function logic [31:0] clamp_u32(longint v);
         if (v > 64'sd4294967295) return 32'hFFFF_FFFF;
         return v[31:0];
      endfunction

      function void write_reg(reg_index_type r, logic [31:0] v);
         case (r)
            REG_ORIGIN_X:      origin_x    = v;
            REG_ORIGIN_Y:      origin_y    = v;
            REG_SCALE_X:       scale_x     = v[15:0];
            REG_SCALE_Y:       scale_y     = v[15:0];
            REG_SPACE_ADVANCE: space_units = v[ADV_W-1:0];
            REG_LINE_HEIGHT:   line_units  = v[ADV_W-1:0];
            default: ;
         endcase
      endfunction

      function void check_register(reg_index_type r, logic [31:0] got);
         logic [31:0] want;
         case (r)
            REG_ORIGIN_X:      want = origin_x;
            REG_ORIGIN_Y:      want = origin_y;
            REG_SCALE_X:       want = {16'd0, scale_x};
            REG_SCALE_Y:       want = {16'd0, scale_y};
            REG_SPACE_ADVANCE: want = {{(32-ADV_W){1'b0}}, space_units};
            default:           want = {{(32-ADV_W){1'b0}}, line_units};
         endcase
         if (got !== want)
            flag($sformatf("register %s read back %h, expected %h", r.name(), got, want));
      endfunction

      // update pen and box for one transferred item, queue any output it causes
      function void advance_pen(glyph_item_type it);
         int                idx;
         longint            px, py, l, t, sx, sy, a, tmp;
         layout_result_type r;
         idx = int'(it.code) - FIRST;
         px  = pen_x;
         py  = pen_y;
         sx  = scale_x;
         sy  = scale_y;
         case (it.op)
            OP_LOAD: begin
               if (idx >= 0 && idx < GLYPHS) begin
                  left_tab[idx]   = it.left;
                  top_tab[idx]    = it.top;
                  w_tab[idx]      = it.w;
                  h_tab[idx]      = it.h;
                  adv_tab[idx]    = it.adv;
                  handle_tab[idx] = it.handle;
                  loaded[idx]     = 1'b1;
               end
            end
            OP_START: begin
               pen_x = origin_x;
               pen_y = origin_y;
               box_x = origin_x;
               box_y = origin_y;
               box_w = 0;
               box_h = 0;
            end
            OP_END: begin
               r.kind   = KIND_BOX;
               r.x      = box_x;
               r.y      = box_y;
               r.w      = box_w;
               r.h      = box_h;
               r.handle = 64'd0;
               due_outputs = {due_outputs, r};
            end
            default: begin
               if (it.code == CODE_SPACE) begin
                  a     = space_units >> ADV_SHIFT;
                  a     = a * sx;
                  pen_x = clamp_s32(px + a);
                  tmp   = box_w;
                  box_w = clamp_u32(tmp + a);
               end else if (it.code == CODE_NEWLINE) begin
                  a     = line_units >> ADV_SHIFT;
                  a     = a * sy;
                  pen_x = origin_x;
                  pen_y = clamp_s32(py + a);
                  tmp   = box_h;
                  box_h = clamp_u32(tmp + a);
               end else if (it.code >= CODE_PRINT_FIRST && it.code <= CODE_PRINT_LAST
                            && idx < GLYPHS) begin
                  l        = left_tab[idx];
                  t        = top_tab[idx];
                  r.kind   = KIND_QUAD;
                  r.x      = clamp_s32(px + l * sx);
                  r.y      = clamp_s32(py - t * sy);
                  tmp      = w_tab[idx];
                  tmp      = tmp * sx;
                  r.w      = tmp[31:0];
                  tmp      = h_tab[idx];
                  tmp      = tmp * sy;
                  r.h      = tmp[31:0];
                  r.handle = handle_tab[idx];
                  due_outputs = {due_outputs, r};
                  a     = adv_tab[idx] >> ADV_SHIFT;
                  a     = a * sx;
                  pen_x = clamp_s32(px + a);
                  if (r.y < box_y) box_y = r.y;
                  tmp   = box_w;
                  box_w = clamp_u32(tmp + longint'(r.w));
                  if (r.h > box_h) box_h = r.h;
               end
            end
         endcase
      endfunction

      function void compare_output(layout_result_type got);
         layout_result_type want;
         if (due_outputs.size() == 0) begin
            flag($sformatf("unexpected output kind %b x %h y %h w %h h %h handle %h",
                           got.kind, got.x, got.y, got.w, got.h, got.handle));
            return;
         end
         want = due_outputs.pop_front();
         if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
             got.w !== want.w || got.h !== want.h || got.handle !== want.handle)
            flag($sformatf({"output mismatch: expected kind %b x %h y %h w %h h %h handle %h,",
                            " got kind %b x %h y %h w %h h %h handle %h"},
                           want.kind, want.x, want.y, want.w, want.h, want.handle,
                           got.kind, got.x, got.y, got.w, got.h, got.handle));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_opcode;
   logic [7:0]             req_char_code;
   logic signed [15:0]     req_bearing_left;
   logic signed [15:0]     req_bearing_top;
   logic [15:0]            req_bitmap_w;
   logic [15:0]            req_bitmap_h;
   logic [ADV_W-1:0]       req_advance_units;
   logic [63:0]            req_texture_ref;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_kind;
   logic signed [31:0]     rsp_pos_x;
   logic signed [31:0]     rsp_pos_y;
   logic [31:0]            rsp_extent_w;
   logic [31:0]            rsp_extent_h;
   logic [63:0]            rsp_glyph_handle;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [4:0]             csr_paddr;
   logic [31:0]            csr_pwdata;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   layout_checker sb;
   bit            idle_on = 1'b1;
   bit            hold_off_request = 1'b0;

   glyph_layout_engine DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_char_code     (req_char_code),
      .req_bearing_left  (req_bearing_left),
      .req_bearing_top   (req_bearing_top),
      .req_bitmap_w      (req_bitmap_w),
      .req_bitmap_h      (req_bitmap_h),
      .req_advance_units (req_advance_units),
      .req_texture_ref   (req_texture_ref),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_extent_w      (rsp_extent_w),
      .rsp_extent_h      (rsp_extent_h),
      .rsp_glyph_handle  (rsp_glyph_handle),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #6 clock = ~clock;

   initial begin
      #12_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic glyph_item_type make_item(opcode_type op, logic [7:0] code);
      glyph_item_type it;
      it.op     = op;
      it.code   = code;
      it.left   = 16'($urandom);
      it.top    = 16'($urandom);
      it.w      = 16'($urandom);
      it.h      = 16'($urandom);
      it.adv    = ADV_W'($urandom);
      it.handle = {$urandom, $urandom};
      return it;
   endfunction

   function automatic logic [7:0] loaded_code();
      int c;
      do c = $urandom_range(FIRST, FIRST + GLYPHS - 1); while (!sb.loaded[c - FIRST]);
      return c[7:0];
   endfunction

   // a character for a well-formed string: never a printable code with no stored glyph
   function automatic logic [7:0] string_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return loaded_code();
      if (r < 78) return CODE_SPACE;
      if (r < 88) return CODE_NEWLINE;
      case ($urandom_range(0, 2))
         0:       return 8'($urandom_range(0, 9));
         1:       return 8'($urandom_range(11, 31));
         default: return 8'($urandom_range(127, 255));
      endcase
   endfunction

   function automatic logic [31:0] rand_origin();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 32'h8000_0000;
      if (r < 30) return 32'h7FFF_FFFF;
      if (r < 60) return $urandom;
      return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
   endfunction

   function automatic logic [31:0] rand_scale();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 32'd0;
      if (r < 30) return 32'd65535;
      if (r < 45) return 32'(SCALE_RESET);
      return $urandom_range(0, 65535);
   endfunction

   function automatic logic [31:0] rand_units();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 32'd0;
      if (r < 30) return 32'h000F_FFFF;
      if (r < 85) return $urandom_range(0, 1 << 14);
      return $urandom_range(0, 32'h000F_FFFF);
   endfunction

   // write a register over APB, then read it back
   task automatic csr_write(reg_index_type r, logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(r, v);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.check_register(r, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // offer one item, hold it until transferred, then optionally drop valid for a gap
   task automatic send_item(glyph_item_type it);
      int gap;
      req_valid         <= 1'b1;
      req_opcode        <= it.op;
      req_char_code     <= it.code;
      req_bearing_left  <= it.left;
      req_bearing_top   <= it.top;
      req_bitmap_w      <= it.w;
      req_bitmap_h      <= it.h;
      req_advance_units <= it.adv;
      req_texture_ref   <= it.handle;
      do @(posedge clock); while (!req_ready);
      sb.advance_pen(it);
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid so nothing is sent twice, then let the block drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.due_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : result_sink
      int                stall_left;
      layout_result_type got;
      stall_left = 0;
      rsp_ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.kind   = rsp_kind;
            got.x      = rsp_pos_x;
            got.y      = rsp_pos_y;
            got.w      = rsp_extent_w;
            got.h      = rsp_extent_h;
            got.handle = rsp_glyph_handle;
            sb.compare_output(got);
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on) stall_left = pick_gap();
         end
      end
   end

   initial begin : stimulus
      glyph_item_type it;
      int             count, n, r;
      logic [7:0]     odd_codes [4];
      logic [7:0]     probe_codes [9];

      sb = new();
      req_valid         <= 1'b0;
      req_opcode        <= OP_LOAD;
      req_char_code     <= 8'd0;
      req_bearing_left  <= 16'd0;
      req_bearing_top   <= 16'd0;
      req_bitmap_w      <= 16'd0;
      req_bitmap_h      <= 16'd0;
      req_advance_units <= '0;
      req_texture_ref   <= 64'd0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= 5'd0;
      csr_pwdata        <= 32'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      odd_codes   = '{8'd0, CODE_SPACE, 8'd127, 8'd255};
      probe_codes = '{8'd33, 8'd126, CODE_SPACE, CODE_NEWLINE, 8'd0, 8'd127, 8'd200,
                      8'd255, 8'd65};

      // directed part, register defaults
      it = make_item(OP_LOAD, CODE_PRINT_FIRST);
      it.left = 16'sh7FFF; it.top = 16'sh8000; it.w = '1; it.h = '1; it.adv = '1;
      it.handle = '1;
      send_item(it);
      it = make_item(OP_LOAD, CODE_PRINT_LAST);
      it.left = 16'sh8000; it.top = 16'sh7FFF; it.w = '0; it.h = '0; it.adv = '0;
      it.handle = '0;
      send_item(it);
      it = make_item(OP_LOAD, 8'd65);
      it.left = 16'sd2; it.top = 16'sd10; it.w = 16'd8; it.h = 16'd12; it.adv = 20'd640;
      send_item(it);
      // loads outside the glyph range are dropped
      foreach (odd_codes[i]) send_item(make_item(OP_LOAD, odd_codes[i]));
      // character and end before any start
      send_item(make_item(OP_CHAR, 8'd65));
      send_item(make_item(OP_END, 8'($urandom)));
      send_item(make_item(OP_START, 8'($urandom)));
      foreach (probe_codes[i]) send_item(make_item(OP_CHAR, probe_codes[i]));
      send_item(make_item(OP_END, 8'($urandom)));
      // empty string
      send_item(make_item(OP_START, 8'($urandom)));
      send_item(make_item(OP_END, 8'($urandom)));

      for (int b = 0; b < BLOCKS; b++) begin
         wait_idle();
         if (b == 0) begin
            csr_write(REG_ORIGIN_X, 32'h7FFF_FFFF);
            csr_write(REG_ORIGIN_Y, 32'h8000_0000);
            csr_write(REG_SCALE_X, 32'd65535);
            csr_write(REG_SCALE_Y, 32'd65535);
            csr_write(REG_SPACE_ADVANCE, 32'h000F_FFFF);
            csr_write(REG_LINE_HEIGHT, 32'h000F_FFFF);
         end else if (b == 1) begin
            csr_write(REG_ORIGIN_X, 32'h8000_0000);
            csr_write(REG_ORIGIN_Y, 32'h7FFF_FFFF);
            csr_write(REG_SCALE_X, 32'd0);
            csr_write(REG_SCALE_Y, 32'd0);
            csr_write(REG_SPACE_ADVANCE, 32'd0);
            csr_write(REG_LINE_HEIGHT, 32'd0);
         end else begin
            csr_write(REG_ORIGIN_X, rand_origin());
            csr_write(REG_ORIGIN_Y, rand_origin());
            csr_write(REG_SCALE_X, rand_scale());
            csr_write(REG_SCALE_Y, rand_scale());
            csr_write(REG_SPACE_ADVANCE, rand_units());
            csr_write(REG_LINE_HEIGHT, rand_units());
         end
         idle_on = (b != 4) && ($urandom_range(0, 4) != 0);
         if (b == 3) hold_off_request = 1'b1;

         count = 0;
         while (count < BLOCK_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               it = make_item(OP_LOAD, ($urandom_range(0, 7) == 0)
                                          ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(FIRST, FIRST + GLYPHS - 1)));
               if ($urandom_range(0, 1) == 0) begin
                  // modest metrics keep the pen off the rails for longer strings
                  it.left = 16'($urandom_range(0, 64) - 32);
                  it.top  = 16'($urandom_range(0, 64) - 32);
                  it.w    = 16'($urandom_range(0, 64));
                  it.h    = 16'($urandom_range(0, 64));
                  it.adv  = ADV_W'($urandom_range(0, 64 * 64));
               end
               send_item(it);
               count++;
            end else if (r < 85) begin
               n = $urandom_range(0, 16);
               send_item(make_item(OP_START, 8'($urandom)));
               repeat (n) send_item(make_item(OP_CHAR, string_code()));
               send_item(make_item(OP_END, 8'($urandom)));
               count += n + 2;
            end else begin
               // noise: any opcode, any code, but no read of an empty glyph slot
               repeat ($urandom_range(1, 4)) begin
                  it = make_item(opcode_type'($urandom_range(0, 3)), 8'($urandom));
                  if (it.op == OP_CHAR && it.code >= CODE_PRINT_FIRST &&
                      it.code <= CODE_PRINT_LAST && !sb.loaded[int'(it.code) - FIRST])
                     it.code = loaded_code();
                  send_item(it);
                  count++;
               end
            end
         end
      end

      wait_idle();
      if (sb.mismatches == 0 && sb.due_outputs.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
